/* rtl/core/lom_pkg.sv */
// Shared types and constants for the layer order manager.
`timescale 1ns / 1ps

package lom_pkg;

  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned HEIGHT_W = 9;
  localparam int unsigned OP_W     = 2;

  // Operation codes; the remaining code is a no-op that reports the slot
  localparam logic [OP_W-1:0] OP_ALLOC      = 2'd0;
  localparam logic [OP_W-1:0] OP_SET_HEIGHT = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE       = 2'd2;

  // Status codes
  localparam logic ST_DONE    = 1'b0;
  localparam logic ST_NO_FREE = 1'b1;

  typedef logic [SLOT_W-1:0]          slot_t;
  typedef logic signed [HEIGHT_W-1:0] height_t;

  // Height of a hidden layer, and top of an empty stack
  localparam height_t HIDDEN = -9'sd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RDH,
    S_CALC,
    S_MOVE,
    S_FIN,
    S_RESP
  } state_e;

  // Kind of list reorder
  typedef enum logic [1:0] {
    MV_LOWER,  // visible layer moves down, entries between shift up
    MV_HIDE,   // visible layer leaves the list, entries above shift down
    MV_RAISE,  // visible layer moves up, entries between shift down
    MV_SHOW    // hidden layer enters the list, entries above shift up
  } move_e;

  // Memory requests: height store and order list, one write and one read each
  typedef struct packed {
    logic    h_we;
    slot_t   h_waddr;
    height_t h_wdata;
    slot_t   h_raddr;
    logic    o_we;
    slot_t   o_waddr;
    slot_t   o_wdata;
    slot_t   o_raddr;
  } mem_req_t;

  typedef struct packed {
    height_t h_rdata;
    slot_t   o_rdata;
  } mem_rsp_t;

endpackage

/* rtl/core/lom_mem.sv */
// Height store and stacking order list, synchronous RAMs with registered reads.
`timescale 1ns / 1ps

module lom_mem #(
  parameter int unsigned SLOTS = 256
) (
  input  logic              clk_i,
  input  lom_pkg::mem_req_t req_i,
  output lom_pkg::mem_rsp_t rsp_o
);

  localparam int unsigned AW = $clog2(SLOTS);

  lom_pkg::height_t height_mem [SLOTS];
  lom_pkg::slot_t   order_mem  [SLOTS];

  lom_pkg::height_t h_rdata_q;
  lom_pkg::slot_t   o_rdata_q;

  // Height store
  always_ff @(posedge clk_i) begin
    if (req_i.h_we) begin
      height_mem[req_i.h_waddr[AW-1:0]] <= req_i.h_wdata;
    end
    h_rdata_q <= height_mem[req_i.h_raddr[AW-1:0]];
  end

  // Order list, bottom layer at position 0
  always_ff @(posedge clk_i) begin
    if (req_i.o_we) begin
      order_mem[req_i.o_waddr[AW-1:0]] <= req_i.o_wdata;
    end
    o_rdata_q <= order_mem[req_i.o_raddr[AW-1:0]];
  end

  assign rsp_o.h_rdata = h_rdata_q;
  assign rsp_o.o_rdata = o_rdata_q;

endmodule

/* rtl/core/layer_order_manager_core.sv */
// Layer order manager top level: slot allocation and stacking order control.
`timescale 1ns / 1ps
//
//  channel  | dir | signals                        | payload
//  ---------+-----+--------------------------------+----------------------------------
//  s_axis   | in  | tvalid, tready, tdata[23:0]    | op, slot, want_height
//  m_axis   | out | tvalid, tready, tdata[31:0]    | status, slot_out, final_height,
//           |     |                                | top_out, repaint
//
//  Allocate walks over in_use from slot 0, one slot per cycle, up to the lowest free slot
//  (over all SLOTS when none is free). Set height and free that reorder move the list
//  entries in between, one per cycle through the order RAM read port.
//  Reset clears in_use flags and top; height and order RAM contents need no clearing.
//  One request at a time; a stalled m_axis holds the next result in its final state.

module layer_order_manager_core #(
  parameter int unsigned NUM_LAYERS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [1:0] op, [9:2] slot, [18:10] want_height
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [0] status, [8:1] slot_out, [17:9] final_height,
                                      // [26:18] top_out, [27] repaint
);

  localparam int unsigned SLOTS = (NUM_LAYERS < 256) ? NUM_LAYERS : 256;
  localparam int unsigned AW    = $clog2(SLOTS);

  lom_pkg::state_e   state_q, state_d;
  lom_pkg::mem_req_t mem_req;
  lom_pkg::mem_rsp_t mem_rsp;

  // Request fields
  logic [lom_pkg::OP_W-1:0] op_q, op_d;
  lom_pkg::slot_t           s_q, s_d;
  lom_pkg::height_t         want_q, want_d;

  // Control state
  logic [SLOTS-1:0]  in_use_q, in_use_d;
  lom_pkg::height_t  top_q, top_d;
  logic [AW-1:0]     scan_q, scan_d;
  logic [8:0]        cnt_q, cnt_d;
  logic              p_q, p_d;
  logic              out_valid_q, out_valid_d;

  // Move bookkeeping
  lom_pkg::height_t h_q, h_d;
  lom_pkg::move_e   kind_q, kind_d;
  logic [8:0]       from_q, from_d;
  logic [8:0]       pto_q, pto_d;

  // Staged and output result
  logic             res_status_q, res_status_d;
  lom_pkg::slot_t   res_slot_q, res_slot_d;
  lom_pkg::height_t res_fh_q, res_fh_d;
  logic             res_rep_q, res_rep_d;
  logic             o_status_q, o_status_d;
  lom_pkg::slot_t   o_slot_q, o_slot_d;
  lom_pkg::height_t o_fh_q, o_fh_d;
  lom_pkg::height_t o_top_q, o_top_d;
  logic             o_rep_q, o_rep_d;

  logic in_accept, in_slot_valid, slot_valid, slot_used;
  logic scan_free, scan_last, out_free, do_chg, change, move_down;
  logic signed [9:0] old_w, top_w, want_w, h_c, from_c, cnt_c;
  lom_pkg::move_e    kind_c;

  lom_mem #(
    .SLOTS (SLOTS)
  ) u_mem (
    .clk_i (clk_i),
    .req_i (mem_req),
    .rsp_o (mem_rsp)
  );

  assign s_axis_tready = (state_q == lom_pkg::S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_slot_valid = {1'b0, s_axis_tdata[9:2]} < 9'(SLOTS);
  assign slot_valid    = {1'b0, s_q} < 9'(SLOTS);
  assign slot_used     = slot_valid && in_use_q[s_q[AW-1:0]];
  assign scan_free     = !in_use_q[scan_q];
  assign scan_last     = (scan_q == AW'(SLOTS - 1));
  assign out_free      = !out_valid_q || m_axis_tready;
  assign move_down     = (kind_q == lom_pkg::MV_LOWER) || (kind_q == lom_pkg::MV_SHOW);

  // Height clamp and reorder plan, from the height read back in S_CALC
  always_comb begin
    old_w  = slot_used ? {mem_rsp.h_rdata[8], mem_rsp.h_rdata} : -10'sd1;
    top_w  = {top_q[8], top_q};
    want_w = (op_q == lom_pkg::OP_FREE) ? -10'sd1 : {want_q[8], want_q};
    h_c    = want_w;
    if (h_c > top_w + 10'sd1) h_c = top_w + 10'sd1;
    if (!old_w[9] && (h_c > top_w)) h_c = top_w;
    if (h_c < -10'sd1) h_c = -10'sd1;
    do_chg = slot_used &&
             ((op_q == lom_pkg::OP_SET_HEIGHT) || (op_q == lom_pkg::OP_FREE));
    change = do_chg && (h_c != old_w);
    if (old_w > h_c) begin
      if (!h_c[9]) begin
        kind_c = lom_pkg::MV_LOWER;
        from_c = old_w - 10'sd1;
        cnt_c  = old_w - h_c;
      end else begin
        kind_c = lom_pkg::MV_HIDE;
        from_c = old_w + 10'sd1;
        cnt_c  = top_w - old_w;
      end
    end else if (!old_w[9]) begin
      kind_c = lom_pkg::MV_RAISE;
      from_c = old_w + 10'sd1;
      cnt_c  = h_c - old_w;
    end else begin
      kind_c = lom_pkg::MV_SHOW;
      from_c = top_w;
      cnt_c  = top_w - h_c + 10'sd1;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lom_pkg::S_IDLE: begin
        if (in_accept) begin
          if (s_axis_tdata[1:0] == lom_pkg::OP_ALLOC) state_d = lom_pkg::S_SCAN;
          else if (in_slot_valid)                     state_d = lom_pkg::S_RDH;
          else                                        state_d = lom_pkg::S_RESP;
        end
      end
      lom_pkg::S_SCAN: if (scan_free || scan_last) state_d = lom_pkg::S_RESP;
      lom_pkg::S_RDH:  state_d = lom_pkg::S_CALC;
      lom_pkg::S_CALC: state_d = change ? lom_pkg::S_MOVE : lom_pkg::S_RESP;
      lom_pkg::S_MOVE: if (cnt_q == '0 && !p_q) state_d = lom_pkg::S_FIN;
      lom_pkg::S_FIN:  state_d = lom_pkg::S_RESP;
      lom_pkg::S_RESP: if (out_free) state_d = lom_pkg::S_IDLE;
      default:         state_d = lom_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory requests and result
  always_comb begin
    op_d         = op_q;
    s_d          = s_q;
    want_d       = want_q;
    in_use_d     = in_use_q;
    top_d        = top_q;
    scan_d       = scan_q;
    cnt_d        = cnt_q;
    p_d          = p_q;
    h_d          = h_q;
    kind_d       = kind_q;
    from_d       = from_q;
    pto_d        = pto_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_fh_d     = res_fh_q;
    res_rep_d    = res_rep_q;
    o_status_d   = o_status_q;
    o_slot_d     = o_slot_q;
    o_fh_d       = o_fh_q;
    o_top_d      = o_top_q;
    o_rep_d      = o_rep_q;
    out_valid_d  = out_valid_q && !m_axis_tready;

    mem_req         = '0;
    mem_req.h_raddr = s_q;
    mem_req.o_raddr = from_q[7:0];

    unique case (state_q)
      lom_pkg::S_IDLE: begin
        if (in_accept) begin
          op_d         = s_axis_tdata[1:0];
          s_d          = s_axis_tdata[9:2];
          want_d       = s_axis_tdata[18:10];
          scan_d       = '0;
          res_status_d = lom_pkg::ST_DONE;
          res_slot_d   = s_axis_tdata[9:2];
          res_fh_d     = lom_pkg::HIDDEN;
          res_rep_d    = 1'b0;
        end
      end
      // walk the in_use flags for the lowest free slot
      lom_pkg::S_SCAN: begin
        scan_d = scan_q + AW'(1);
        if (scan_free) begin
          in_use_d[scan_q] = 1'b1;
          res_slot_d       = 8'(scan_q);
          mem_req.h_we     = 1'b1;
          mem_req.h_waddr  = 8'(scan_q);
          mem_req.h_wdata  = lom_pkg::HIDDEN;
        end else if (scan_last) begin
          res_status_d = lom_pkg::ST_NO_FREE;
          res_slot_d   = '0;
        end
      end
      lom_pkg::S_RDH: begin
      end
      lom_pkg::S_CALC: begin
        if (change) begin
          res_fh_d = h_c[8:0];
          h_d      = h_c[8:0];
          kind_d   = kind_c;
          from_d   = from_c[8:0];
          cnt_d    = cnt_c[8:0];
          p_d      = 1'b0;
        end else begin
          res_fh_d = old_w[8:0];
          if ((op_q == lom_pkg::OP_FREE) && slot_used) in_use_d[s_q[AW-1:0]] = 1'b0;
        end
      end
      // one entry read per cycle, written to its neighbor position in the next cycle
      lom_pkg::S_MOVE: begin
        if (cnt_q != '0) begin
          p_d    = 1'b1;
          pto_d  = move_down ? (from_q + 9'd1) : (from_q - 9'd1);
          from_d = move_down ? (from_q - 9'd1) : (from_q + 9'd1);
          cnt_d  = cnt_q - 9'd1;
        end else begin
          p_d = 1'b0;
        end
        if (p_q) begin
          mem_req.o_we    = 1'b1;
          mem_req.o_waddr = pto_q[7:0];
          mem_req.o_wdata = mem_rsp.o_rdata;
          mem_req.h_we    = {1'b0, mem_rsp.o_rdata} < 9'(SLOTS);
          mem_req.h_waddr = mem_rsp.o_rdata;
          mem_req.h_wdata = signed'(pto_q);
        end
      end
      // place the slot itself, settle top, and release the slot of a free
      lom_pkg::S_FIN: begin
        mem_req.h_we    = 1'b1;
        mem_req.h_waddr = s_q;
        mem_req.h_wdata = h_q;
        res_rep_d       = 1'b1;
        if (kind_q == lom_pkg::MV_HIDE) begin
          top_d = top_q - 9'sd1;
        end else begin
          mem_req.o_we    = 1'b1;
          mem_req.o_waddr = h_q[7:0];
          mem_req.o_wdata = s_q;
          if (kind_q == lom_pkg::MV_SHOW) top_d = top_q + 9'sd1;
        end
        if (op_q == lom_pkg::OP_FREE) in_use_d[s_q[AW-1:0]] = 1'b0;
      end
      lom_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_status_d  = res_status_q;
          o_slot_d    = res_slot_q;
          o_fh_d      = res_fh_q;
          o_top_d     = top_q;
          o_rep_d     = res_rep_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lom_pkg::S_IDLE;
      in_use_q    <= '0;
      top_q       <= lom_pkg::HIDDEN;
      scan_q      <= '0;
      cnt_q       <= '0;
      p_q         <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_use_q    <= in_use_d;
      top_q       <= top_d;
      scan_q      <= scan_d;
      cnt_q       <= cnt_d;
      p_q         <= p_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    s_q          <= s_d;
    want_q       <= want_d;
    h_q          <= h_d;
    kind_q       <= kind_d;
    from_q       <= from_d;
    pto_q        <= pto_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_fh_q     <= res_fh_d;
    res_rep_q    <= res_rep_d;
    o_status_q   <= o_status_d;
    o_slot_q     <= o_slot_d;
    o_fh_q       <= o_fh_d;
    o_top_q      <= o_top_d;
    o_rep_q      <= o_rep_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, o_rep_q, o_top_q, o_fh_q, o_slot_q, o_status_q};

`ifndef NO_ASSERTIONS
  // overlapped moves never read the list entry that is being written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lom_pkg::S_MOVE && p_q && cnt_q != '0) |->
      (mem_req.o_waddr != mem_req.o_raddr))
    else $error("order list read and write collide during move");

  // the slot is placed only after the move pipeline has drained
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lom_pkg::S_FIN) |-> (!p_q && cnt_q == '0))
    else $error("final placement before moves finished");

  // top stays within the slot range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !top_q[8] |-> ({1'b0, top_q} < 10'(SLOTS)))
    else $error("top beyond slot range");

  // a result appears only out of the response state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == lom_pkg::S_RESP))
    else $error("result raised outside response state");
`endif

endmodule

/* tb/sv/layer_order_manager_core_tb.sv */
// Self-checking testbench for the layer order manager core: slots, stacking and repaint.
`timescale 1ns / 1ps

module layer_order_manager_core_tb;

  localparam int SLOTS       = 256;
  localparam int HOLD_CYCLES = 500;
  // Code 3 does nothing but report the slot
  localparam logic [lom_pkg::OP_W-1:0] OP_NOP = 2'd3;

  // Result fields, packed as on m_axis_tdata[27:0]
  typedef struct packed {
    logic             repaint;
    lom_pkg::height_t top;
    lom_pkg::height_t fh;
    lom_pkg::slot_t   slot;
    logic             status;
  } lom_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;   // [1:0] op, [9:2] slot, [18:10] want_height
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // [0] status, [8:1] slot_out, [17:9] final_height,
                                     // [26:18] top_out, [27] repaint

  // Shadow copy of the layer tables
  logic           lyr_used   [SLOTS];
  int             lyr_height [SLOTS];
  lom_pkg::slot_t lyr_order  [SLOTS];
  int             lyr_top;
  int             lyr_used_count;

  lom_result_t layer_results_due[$];
  lom_result_t seen_r;
  lom_result_t due_r;

  int err_count      = 0;
  int results_seen   = 0;
  int op_tally [4]   = '{default: 0};
  int no_free_seen   = 0;
  int peak_top       = -1;
  int src_idle_pct   = 0;
  int snk_stall_pct  = 0;
  logic hold_trig    = 1'b0;
  logic hold_seen    = 1'b0;
  int   hold_left    = 0;

  layer_order_manager_core #(
    .NUM_LAYERS(SLOTS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Copy a list entry one position and renumber the layer it holds
  function automatic void shift_entry(input int from, input int to);
    lom_pkg::slot_t s;
    s = (from >= 0 && from < SLOTS) ? lyr_order[from] : '0;
    if (to >= 0 && to < SLOTS) lyr_order[to] = s;
    lyr_height[s] = to;
  endfunction

  // Move one layer to a clamped height; returns 1 when the order changed
  function automatic logic restack(input lom_pkg::slot_t s, input int want);
    int old;
    int h;
    int k;
    old = lyr_height[s];
    h   = want;
    if (h > lyr_top + 1) h = lyr_top + 1;
    // a visible layer is already counted in the list
    if (old >= 0 && h > lyr_top) h = lyr_top;
    if (h < -1) h = -1;
    if (h == old) return 1'b0;
    lyr_height[s] = h;
    if (old > h) begin
      if (h >= 0) begin
        for (k = old; k > h; k--) shift_entry(k - 1, k);
        lyr_order[h] = s;
      end else begin
        for (k = old; k < lyr_top; k++) shift_entry(k + 1, k);
        lyr_top--;
      end
    end else begin
      if (old >= 0) begin
        for (k = old; k < h; k++) shift_entry(k + 1, k);
        lyr_order[h] = s;
      end else begin
        for (k = lyr_top; k >= h; k--) shift_entry(k, k + 1);
        lyr_order[h] = s;
        lyr_top++;
      end
    end
    return 1'b1;
  endfunction

  // Apply one request to the shadow tables and return the result it must give
  function automatic lom_result_t predict_layer_op(input logic [lom_pkg::OP_W-1:0] op,
                                                   input lom_pkg::slot_t s,
                                                   input lom_pkg::height_t want);
    lom_result_t r;
    logic        found;
    int          i;
    r      = '0;
    r.slot = s;
    r.fh   = lom_pkg::HIDDEN;
    found  = 1'b0;
    case (op)
      lom_pkg::OP_ALLOC: begin
        r.slot   = '0;
        r.status = lom_pkg::ST_NO_FREE;
        for (i = 0; i < SLOTS; i++) begin
          if (!found && !lyr_used[i]) begin
            found         = 1'b1;
            lyr_used[i]   = 1'b1;
            lyr_height[i] = -1;
            r.slot        = lom_pkg::slot_t'(i);
            r.status      = lom_pkg::ST_DONE;
            lyr_used_count++;
          end
        end
      end
      lom_pkg::OP_SET_HEIGHT: begin
        if (lyr_used[s]) r.repaint = restack(s, int'(want));
      end
      lom_pkg::OP_FREE: begin
        if (lyr_used[s]) begin
          if (lyr_height[s] >= 0) r.repaint = restack(s, -1);
          lyr_used[s] = 1'b0;
          lyr_used_count--;
        end
      end
      default: ;
    endcase
    if (op != lom_pkg::OP_ALLOC) r.fh = lom_pkg::height_t'(lyr_height[s]);
    r.top = lom_pkg::height_t'(lyr_top);
    return r;
  endfunction

  // Some slot in use, or a random one when none is
  function automatic lom_pkg::slot_t pick_used_slot();
    int base;
    int i;
    base = $urandom_range(SLOTS - 1);
    for (i = 0; i < SLOTS; i++) begin
      if (lyr_used[(base + i) % SLOTS]) return lom_pkg::slot_t'((base + i) % SLOTS);
    end
    return lom_pkg::slot_t'(base);
  endfunction

  // Heights mostly around the current stack, sometimes anywhere in range
  function automatic lom_pkg::height_t pick_height();
    int sel;
    sel = $urandom_range(99);
    if (sel < 55) return lom_pkg::height_t'(int'($urandom_range(lyr_top + 3)) - 2);
    if (sel < 65) return lom_pkg::HIDDEN;
    if (sel < 75) return lom_pkg::height_t'(lyr_top);
    if (sel < 85) return lom_pkg::height_t'(lyr_top + 1);
    return lom_pkg::height_t'($urandom_range(511));
  endfunction

  // Offer one request and record its expected result once it is taken
  task automatic send_req(input logic [lom_pkg::OP_W-1:0] op, input lom_pkg::slot_t s,
                          input lom_pkg::height_t want);
    lom_result_t exp_r;
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, want, s, op};
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    exp_r = predict_layer_op(op, s, want);
    layer_results_due.push_back(exp_r);
    op_tally[op]++;
    if (exp_r.status == lom_pkg::ST_NO_FREE) no_free_seen++;
    if (lyr_top > peak_top) peak_top = lyr_top;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (layer_results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic compare_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      err_count++;
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_r = m_axis_tdata[27:0];
      results_seen++;
      if (layer_results_due.size() == 0) begin
        $error("result with no pending request: slot_out %0d", seen_r.slot);
        err_count++;
      end else begin
        due_r = layer_results_due.pop_front();
        compare_field("status", due_r.status, seen_r.status);
        compare_field("slot_out", due_r.slot, seen_r.slot);
        compare_field("final_height", int'(due_r.fh), int'(seen_r.fh));
        compare_field("top_out", int'(due_r.top), int'(seen_r.top));
        compare_field("repaint", due_r.repaint, seen_r.repaint);
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk_i) begin
    if (hold_trig != hold_seen) begin
      hold_seen <= hold_trig;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver ready with random stalls
  always @(posedge clk_i) begin
    m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
  end

  // Every operation and corner case on a small stack
  task automatic test_directed();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    send_req(lom_pkg::OP_ALLOC, 8'd0, 9'sd0);
    send_req(lom_pkg::OP_ALLOC, 8'd255, 9'sd255);
    send_req(lom_pkg::OP_ALLOC, 8'd7, -9'sd256);
    send_req(lom_pkg::OP_ALLOC, 8'd0, lom_pkg::HIDDEN);
    send_req(lom_pkg::OP_SET_HEIGHT, 8'd0, 9'sd0);       // show on empty stack
    send_req(lom_pkg::OP_SET_HEIGHT, 8'd1, 9'sd255);     // clamp to top + 1
    send_req(lom_pkg::OP_SET_HEIGHT, 8'd2, -9'sd256);    // hidden stays hidden
    send_req(lom_pkg::OP_SET_HEIGHT, 8'd2, 9'sd0);       // insert at bottom
    send_req(lom_pkg::OP_SET_HEIGHT, 8'd2, 9'sd255);     // raise visible, clamp to top
    send_req(lom_pkg::OP_SET_HEIGHT, 8'd2, 9'sd2);       // same height
    send_req(lom_pkg::OP_SET_HEIGHT, 8'd2, 9'sd0);       // lower
    send_req(lom_pkg::OP_SET_HEIGHT, 8'd3, 9'sd1);       // insert in the middle
    send_req(lom_pkg::OP_SET_HEIGHT, 8'd0, lom_pkg::HIDDEN);  // hide visible
    send_req(lom_pkg::OP_SET_HEIGHT, 8'd200, 9'sd5);     // slot not in use
    send_req(lom_pkg::OP_FREE, 8'd201, 9'sd0);           // free a free slot
    send_req(lom_pkg::OP_FREE, 8'd1, 9'sd0);             // free a visible slot
    send_req(lom_pkg::OP_FREE, 8'd0, 9'sd0);             // free a hidden slot
    send_req(OP_NOP, 8'd2, 9'sd0);
    send_req(OP_NOP, 8'd255, -9'sd256);
    send_req(lom_pkg::OP_SET_HEIGHT, 8'd255, 9'sd255);
    send_req(lom_pkg::OP_FREE, 8'd255, lom_pkg::HIDDEN);
    send_req(lom_pkg::OP_ALLOC, 8'd0, 9'sd0);            // lowest free slot reused
    send_req(lom_pkg::OP_SET_HEIGHT, 8'd0, -9'sd2);      // clamp below hidden
    send_req(lom_pkg::OP_SET_HEIGHT, 8'd3, lom_pkg::HIDDEN);
    send_req(lom_pkg::OP_FREE, 8'd2, 9'sd0);
    settle_block();
  endtask

  // Use every slot, run out, build a deep stack, then tear part of it down
  task automatic test_full_stack();
    int n;
    src_idle_pct  = 29;
    snk_stall_pct = 29;
    while (lyr_used_count < SLOTS) begin
      send_req(lom_pkg::OP_ALLOC, lom_pkg::slot_t'($urandom_range(255)), pick_height());
    end
    repeat (2) send_req(lom_pkg::OP_ALLOC, lom_pkg::slot_t'($urandom_range(255)),
                        pick_height());
    for (n = 0; n < SLOTS; n++) begin
      send_req(lom_pkg::OP_SET_HEIGHT, lom_pkg::slot_t'(n), pick_height());
    end
    repeat (100) send_req(lom_pkg::OP_FREE, pick_used_slot(), pick_height());
    settle_block();
  endtask

  // Random traffic, mostly on slots in use
  task automatic test_random_mix(input int n_items, input int src_pct, input int snk_pct);
    int                       n;
    int                       sel;
    int                       alloc_pct;
    logic [lom_pkg::OP_W-1:0] op;
    lom_pkg::slot_t           s;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    for (n = 0; n < n_items; n++) begin
      alloc_pct = (lyr_used_count < 24) ? 30 : 12;
      sel = $urandom_range(99);
      if (sel < alloc_pct) op = lom_pkg::OP_ALLOC;
      else if (sel < 72)   op = lom_pkg::OP_SET_HEIGHT;
      else if (sel < 90)   op = lom_pkg::OP_FREE;
      else                 op = OP_NOP;
      s = ($urandom_range(9) < 8) ? pick_used_slot() : lom_pkg::slot_t'($urandom_range(255));
      send_req(op, s, pick_height());
    end
    settle_block();
  endtask

  // Receiver holds off while requests keep coming, so the input backs up
  task automatic test_backpressure();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_trig <= ~hold_trig;
    repeat (30) send_req(($urandom_range(3) == 0) ? lom_pkg::OP_ALLOC : lom_pkg::OP_SET_HEIGHT,
                         pick_used_slot(), pick_height());
    settle_block();
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      lyr_used[i]   = 1'b0;
      lyr_height[i] = -1;
      lyr_order[i]  = '0;
    end
    lyr_top        = -1;
    lyr_used_count = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_stack();
    test_random_mix(110, 0, 0);
    test_random_mix(110, 81, 0);
    test_random_mix(110, 0, 81);
    test_random_mix(110, 29, 29);
    test_backpressure();

    $display("Run covered %0d requests: %0d allocate, %0d set height, %0d free, %0d no-op.",
             op_tally[0] + op_tally[1] + op_tally[2] + op_tally[3],
             op_tally[0], op_tally[1], op_tally[2], op_tally[3]);
    $display("%0d results compared; deepest stack %0d layers; allocate found none free %0d times.",
             results_seen, peak_top + 1, no_free_seen);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #60_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* layer_order_manager_core.f */
rtl/core/lom_pkg.sv
rtl/core/lom_mem.sv
rtl/core/layer_order_manager_core.sv
tb/sv/layer_order_manager_core_tb.sv
